@@ rtl/i2da_pkg.sv @@
// i2da_pkg: shared constants and sizing functions for the integer to decimal text block
// no dependencies; imported by every module of the block but i2da_fifo
`default_nettype none

package i2da_pkg;

    localparam int DEF_VALUE_WIDTH = 32;
    localparam int DEF_QUEUE_DEPTH = 2;

    // binary bits folded into the bcd register per cycle
    localparam int BITS_PER_STEP = 4;

    localparam int CHAR_W     = 6;
    localparam int OUT_DATA_W = 8;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

    // decimal digits that cover any magnitude up to 2**w - 1 (1233/4096 ~ log10 2)
    function automatic int num_digits(input int w);
        return ((w * 1233) >> 12) + 1;
    endfunction

    function automatic int in_data_width(input int w);
        return ((w + 7) >> 3) << 3;
    endfunction

    // queue word: sign, digit count, bcd digits
    function automatic int entry_width(input int w);
        return 1 + $clog2(num_digits(w) + 1) + 4 * num_digits(w);
    endfunction

endpackage

`default_nettype wire

@@ rtl/i2da_fifo.sv @@
// i2da_fifo: small register queue between the converter front and the emitter back
// depends on nothing but its parameters
`default_nettype none

module i2da_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/i2da_front.sv @@
// i2da_front: accepts a word, splits off the sign and converts the magnitude to bcd
// uses i2da_pkg; feeds i2da_fifo
`default_nettype none

module i2da_front #(
    parameter int VALUE_WIDTH = i2da_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire logic [i2da_pkg::in_data_width(VALUE_WIDTH)-1:0] s_tdata,
    output logic      push_valid,
    input  wire logic push_ready,
    output logic [i2da_pkg::entry_width(VALUE_WIDTH)-1:0] push_data
);

    import i2da_pkg::*;

    localparam int ND     = num_digits(VALUE_WIDTH);
    localparam int BCD_W  = 4 * ND;
    localparam int CNT_W  = $clog2(ND + 1);
    localparam int STEPS  = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int PAD_W  = STEPS * BITS_PER_STEP;
    localparam int STEP_W = $clog2(STEPS + 1);

    logic                   busy_reg, busy_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [PAD_W-1:0]       bin_reg, bin_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic                   neg_reg, neg_next;

    logic [VALUE_WIDTH-1:0] val;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   done, accept;
    logic [PAD_W-1:0]       bin_step;
    logic [BCD_W-1:0]       bcd_step;
    logic [CNT_W-1:0]       ndig;

    assign val    = s_tdata[VALUE_WIDTH-1:0];
    // the most negative value wraps onto its own unsigned magnitude
    assign mag    = val[VALUE_WIDTH-1] ? (~val + 1'b1) : val;
    assign done   = busy_reg && (step_reg == '0);
    assign accept = s_tvalid && s_tready;

    assign s_tready   = !busy_reg || (done && push_ready);
    assign push_valid = done;
    assign push_data  = {neg_reg, ndig, bcd_reg};

    // shift-add-3, one binary bit per inner pass
    always_comb
    begin
        logic [BCD_W-1:0] b;
        logic [PAD_W-1:0] s;
        b = bcd_reg;
        s = bin_reg;
        for (int k = 0; k < BITS_PER_STEP; k++)
        begin
            for (int d = 0; d < ND; d++)
            begin
                if (b[d*4 +: 4] > 4'd4)
                begin
                    b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
                end
            end
            b = {b[BCD_W-2:0], s[PAD_W-1]};
            s = {s[PAD_W-2:0], 1'b0};
        end
        bcd_step = b;
        bin_step = s;
    end

    // digit count: position of the highest nonzero digit, at least one digit
    always_comb
    begin
        ndig = CNT_W'(1);
        for (int d = 0; d < ND; d++)
        begin
            if (bcd_reg[d*4 +: 4] != 4'd0)
            begin
                ndig = CNT_W'(d + 1);
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        neg_next  = neg_reg;
        if (done && push_ready)
        begin
            busy_next = 1'b0;
        end
        if (busy_reg && (step_reg != '0))
        begin
            bin_next  = bin_step;
            bcd_next  = bcd_step;
            step_next = step_reg - 1'b1;
        end
        if (accept)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(STEPS);
            bin_next  = PAD_W'(mag);
            bcd_next  = '0;
            neg_next  = val[VALUE_WIDTH-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

endmodule

`default_nettype wire

@@ rtl/i2da_back.sv @@
// i2da_back: takes converted words off the queue and sends their text one character a cycle while the receiver is ready
// uses i2da_pkg; fed by i2da_fifo
`default_nettype none

module i2da_back #(
    parameter int VALUE_WIDTH = i2da_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic pop_valid,
    output logic      pop_ready,
    input  wire logic [i2da_pkg::entry_width(VALUE_WIDTH)-1:0] pop_data,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output logic [i2da_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic      m_tlast
);

    import i2da_pkg::*;

    localparam int ND      = num_digits(VALUE_WIDTH);
    localparam int BCD_W   = 4 * ND;
    localparam int CNT_W   = $clog2(ND + 1);
    localparam int IDX_W   = $clog2(ND);
    localparam int ENTRY_W = entry_width(VALUE_WIDTH);

    logic              active_reg, active_next;
    logic              sign_reg, sign_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic              valid_reg, valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;

    logic              p_neg;
    logic [CNT_W-1:0]  p_ndig;
    logic [BCD_W-1:0]  p_bcd;
    logic              out_free, emit, final_emit, pop;
    logic [3:0]        digit;

    assign p_neg  = pop_data[ENTRY_W-1];
    assign p_ndig = pop_data[BCD_W +: CNT_W];
    assign p_bcd  = pop_data[BCD_W-1:0];

    assign out_free   = !valid_reg || m_tready;
    assign emit       = active_reg && out_free;
    assign final_emit = emit && !sign_reg && (idx_reg == '0);
    // next word loads on the same edge as the final character of this one
    assign pop_ready  = !active_reg || final_emit;
    assign pop        = pop_valid && pop_ready;
    assign digit      = bcd_reg[idx_reg*4 +: 4];

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - CHAR_W){1'b0}}, char_reg};
    assign m_tlast  = last_reg;

    always_comb
    begin
        active_next = active_reg;
        sign_next   = sign_reg;
        idx_next    = idx_reg;
        bcd_next    = bcd_reg;
        valid_next  = valid_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        if (out_free)
        begin
            valid_next = active_reg;
        end
        if (emit)
        begin
            if (sign_reg)
            begin
                char_next = ASCII_MINUS;
                last_next = 1'b0;
                sign_next = 1'b0;
            end
            else
            begin
                char_next = ASCII_ZERO + CHAR_W'(digit);
                last_next = (idx_reg == '0);
                if (idx_reg != '0)
                begin
                    idx_next = idx_reg - 1'b1;
                end
                else
                begin
                    active_next = 1'b0;
                end
            end
        end
        if (pop)
        begin
            active_next = 1'b1;
            sign_next   = p_neg;
            idx_next    = IDX_W'(p_ndig - 1'b1);
            bcd_next    = p_bcd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sign_reg <= sign_next;
        idx_reg  <= idx_next;
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

`default_nettype wire

@@ rtl/int_to_decimal_ascii.sv @@
// int_to_decimal_ascii: signed integer to decimal ascii text, top level
// uses i2da_pkg, i2da_front, i2da_fifo, i2da_back
//
// usage:
//   slave channel: one word per integer, two's complement value in the low
//   VALUE_WIDTH bits of s_tdata. master channel: one word per character,
//   most significant first; '-' leads a negative value, zero gives "0",
//   m_tlast marks the final character of each number.
//   the front converts the magnitude to bcd four bits a cycle and takes a new
//   integer only when idle or as its current result enters the queue, which
//   must have room. the back sends one character a cycle while the receiver
//   is ready; a number has up to 11 characters at 32 bits, and the output
//   rate sets the sustained throughput for long texts.
//   a stalled receiver holds the current character in the output register;
//   the queue then fills and s_tready drops once the front holds a result.
//   reset clears the front, queue and output valid; no word is lost or
//   repeated across any stall pattern.
`default_nettype none

module int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = i2da_pkg::DEF_VALUE_WIDTH,
    parameter int QUEUE_DEPTH = i2da_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // value
    input  wire logic [i2da_pkg::in_data_width(VALUE_WIDTH)-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // character, zero padding
    output logic [i2da_pkg::OUT_DATA_W-1:0] m_tdata,
    // last_char
    output logic      m_tlast
);

    import i2da_pkg::*;

    localparam int ENTRY_W = entry_width(VALUE_WIDTH);

    logic               push_valid, push_ready;
    logic [ENTRY_W-1:0] push_data;
    logic               pop_valid, pop_ready;
    logic [ENTRY_W-1:0] pop_data;

    i2da_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    i2da_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    i2da_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/i2da_check.sv @@
// i2da_check: port-level assertions for int_to_decimal_ascii, bound to the top level
// uses i2da_pkg
`default_nettype none

module i2da_check (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [i2da_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic m_tlast
);

    import i2da_pkg::*;

    // output is quiet from the edge after reset is seen
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("output word valid during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output word changed");

    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[CHAR_W-1:0] == ASCII_MINUS)
            || ((m_tdata[CHAR_W-1:0] >= ASCII_ZERO)
                && (m_tdata[CHAR_W-1:0] <= ASCII_ZERO + 6'd9)))
        else $error("character outside sign and digits");

    // a sign never ends a number
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[CHAR_W-1:0] == ASCII_MINUS) |-> !m_tlast)
        else $error("sign marked as last character");

    // a sign is always followed by a digit, never by another sign
    a_no_double_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && (m_tdata[CHAR_W-1:0] == ASCII_MINUS)
            |=> !(m_tvalid && (m_tdata[CHAR_W-1:0] == ASCII_MINUS)))
        else $error("two signs in a row");

endmodule

bind int_to_decimal_ascii i2da_check u_i2da_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
